>>> rtl/fpbs_pkg.sv
// fpbs_pkg: shared types and constants for the binary64 power-by-squaring unit
// no dependencies
`timescale 1ns / 1ps

package fpbs_pkg;

	// working exponent, biased, wide enough for products and subnormal pre-shift
	typedef logic signed [12:0] fexp_t;

	localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DEF_NAN_BITS = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
	localparam logic [10:0] EXP_MAX      = 11'h7FF;
	localparam fexp_t       EXP_BIAS     = 13'sd1023;

endpackage

>>> rtl/fpbs_fmul.sv
// fpbs_fmul: shared multi-cycle IEEE binary64 multiplier, round to nearest even
// uses fpbs_pkg; 27x27 partial products, one per cycle
`timescale 1ns / 1ps

module fpbs_fmul
	import fpbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] y
);

	typedef enum logic [2:0] {S_IDLE, S_NORM, S_MUL, S_SHF, S_RND, S_DONE} state_t;

	state_t       state_q;
	logic         sign_q;
	logic [52:0]  ma_q, mb_q;
	fexp_t        ea_q, eb_q;
	logic [105:0] prod_q;
	logic [53:0]  pp_q;
	logic [6:0]   psh_q;
	logic [2:0]   step_q;
	logic [52:0]  mant_q;
	logic         guard_q, sticky_q;
	logic [10:0]  er_q;
	logic [63:0]  y_q;

	// operand classification
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	assign a_nan  = (a[62:52] == EXP_MAX) && (a[51:0] != '0);
	assign b_nan  = (b[62:52] == EXP_MAX) && (b[51:0] != '0);
	assign a_inf  = (a[62:52] == EXP_MAX) && (a[51:0] == '0);
	assign b_inf  = (b[62:52] == EXP_MAX) && (b[51:0] == '0);
	assign a_zero = (a[62:0] == '0);
	assign b_zero = (b[62:0] == '0);

	// partial product operand select
	logic [26:0] px, py;
	assign px = step_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
	assign py = step_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];

	// normalize, exponent and subnormal right shift
	logic [105:0] pn, pshifted;
	fexp_t        er, shamt;
	logic [6:0]   sh;
	logic         lost;
	always_comb begin
		pn = prod_q[105] ? prod_q : {prod_q[104:0], 1'b0};
		er = ea_q + eb_q - EXP_BIAS + fexp_t'({12'b0, prod_q[105]});
		shamt = fexp_t'(13'sd1) - er;
		if (er > fexp_t'(13'sd0)) begin
			sh = '0;
		end else if (shamt > fexp_t'(13'sd107)) begin
			sh = 7'd107;
		end else begin
			sh = shamt[6:0];
		end
		pshifted = pn >> sh;
		lost = ((pshifted << sh) != pn);
	end

	// rounding and packing
	logic        rinc;
	logic [53:0] mrnd;
	logic [62:0] packed_mag;
	always_comb begin
		rinc = guard_q && (sticky_q || mant_q[0]);
		mrnd = {1'b0, mant_q} + {53'b0, rinc};
		packed_mag = {er_q - 11'd1, 52'b0} + {9'b0, mrnd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sign_q <= a[63] ^ b[63];
						ma_q   <= {(a[62:52] != '0), a[51:0]};
						mb_q   <= {(b[62:52] != '0), b[51:0]};
						ea_q   <= (a[62:52] == '0) ? fexp_t'(13'sd1) : fexp_t'({2'b0, a[62:52]});
						eb_q   <= (b[62:52] == '0) ? fexp_t'(13'sd1) : fexp_t'({2'b0, b[62:52]});
						step_q <= '0;
						if (a_nan) begin
							y_q <= a | QUIET_BIT;
							state_q <= S_DONE;
						end else if (b_nan) begin
							y_q <= b | QUIET_BIT;
							state_q <= S_DONE;
						end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
							y_q <= DEF_NAN_BITS;
							state_q <= S_DONE;
						end else if (a_inf || b_inf) begin
							y_q <= {a[63] ^ b[63], EXP_MAX, 52'b0};
							state_q <= S_DONE;
						end else if (a_zero || b_zero) begin
							y_q <= {a[63] ^ b[63], 63'b0};
							state_q <= S_DONE;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					// subnormal operands: one bit of left shift per cycle
					if (!ma_q[52]) begin
						ma_q <= {ma_q[51:0], 1'b0};
						ea_q <= ea_q - fexp_t'(13'sd1);
					end else if (!mb_q[52]) begin
						mb_q <= {mb_q[51:0], 1'b0};
						eb_q <= eb_q - fexp_t'(13'sd1);
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					pp_q  <= px * py;
					psh_q <= (step_q[1] ? 7'd27 : 7'd0) + (step_q[0] ? 7'd27 : 7'd0);
					if (step_q == 3'd0) begin
						prod_q <= '0;
					end else begin
						prod_q <= prod_q + ({52'b0, pp_q} << psh_q);
					end
					if (step_q == 3'd4) begin
						state_q <= S_SHF;
					end
					step_q <= step_q + 3'd1;
				end
				S_SHF: begin
					if (er >= fexp_t'(13'sd2047)) begin
						y_q <= {sign_q, EXP_MAX, 52'b0};
						state_q <= S_DONE;
					end else begin
						mant_q   <= pshifted[105:53];
						guard_q  <= pshifted[52];
						sticky_q <= (pshifted[51:0] != '0) || lost;
						er_q     <= (er > fexp_t'(13'sd0)) ? er[10:0] : 11'd1;
						state_q  <= S_RND;
					end
				end
				S_RND: begin
					y_q <= {sign_q, packed_mag};
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_DONE);
	assign y    = y_q;

endmodule

>>> rtl/float_power_by_squaring_unit.sv
// float_power_by_squaring_unit: binary64 base raised to an unsigned integer power
// uses fpbs_pkg and fpbs_fmul (one shared multiplier under a bit sequencer)
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, base_bits,   | item in
//          | power                            |
//  out     | out_valid, out_stall, result_bits| item out
//
// one item at a time: in_stall is high from acceptance until the result is
// loaded into the output register, which then waits on out_stall while a new
// item is taken
// each exponent bit costs one square plus, when set, one multiply by the base;
// a multiply passes through start, normalize check, the partial product steps,
// shift, round and done, with extra normalize steps for a subnormal operand;
// a nan, infinite or zero operand goes from start straight to done
// arst_n clears the sequencer and output valid; data registers are not reset
`timescale 1ns / 1ps

module float_power_by_squaring_unit
	import fpbs_pkg::*;
#(
	parameter int POWER_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [63:0]           base_bits,
	input  logic [POWER_BITS-1:0] power,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           result_bits
);

	localparam int CW = $clog2(POWER_BITS + 1);

	typedef enum logic [2:0] {T_IDLE, T_SQ, T_SQW, T_MUL, T_MULW, T_OUT} tstate_t;

	tstate_t               state_q;
	logic [63:0]           acc_q;
	logic [63:0]           base_q;
	logic [POWER_BITS-1:0] pw_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;
	logic [63:0]           result_q;

	// shared multiplier: square uses acc twice, set bits use base times acc
	logic        mul_start, mul_done;
	logic [63:0] mul_a, mul_y;
	assign mul_start = (state_q == T_SQ) || (state_q == T_MUL);
	assign mul_a     = (state_q == T_MUL) ? base_q : acc_q;

	fpbs_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (acc_q),
		.done   (mul_done),
		.y      (mul_y)
	);

	logic in_accept;
	assign in_accept = in_valid && (state_q == T_IDLE);

	// result moves into the output register once that register is free
	logic out_load;
	assign out_load = (state_q == T_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// output register drains independent of the sequencer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_accept) begin
						acc_q   <= ONE_BITS;
						base_q  <= base_bits;
						pw_q    <= power;
						cnt_q   <= CW'(POWER_BITS);
						state_q <= T_SQ;
					end
				end
				T_SQ: begin
					state_q <= T_SQW;
				end
				T_SQW: begin
					if (mul_done) begin
						acc_q <= mul_y;
						if (pw_q[POWER_BITS-1]) begin
							state_q <= T_MUL;
						end else begin
							// bit clear: move on to the next exponent bit
							pw_q  <= pw_q << 1;
							cnt_q <= cnt_q - CW'(1);
							state_q <= (cnt_q == CW'(1)) ? T_OUT : T_SQ;
						end
					end
				end
				T_MUL: begin
					state_q <= T_MULW;
				end
				T_MULW: begin
					if (mul_done) begin
						acc_q <= mul_y;
						pw_q  <= pw_q << 1;
						cnt_q <= cnt_q - CW'(1);
						state_q <= (cnt_q == CW'(1)) ? T_OUT : T_SQ;
					end
				end
				T_OUT: begin
					// hand the result over once the output register is free
					if (out_load) begin
						result_q <= acc_q;
						state_q  <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != T_IDLE);
	assign out_valid   = out_valid_q;
	assign result_bits = result_q;

endmodule
